// ===== hw/rtl/imei_pkg.sv =====
// ----------------------------------------------------------------------------
// Inverted Mandelbrot escape-time package
// Shared constants, payload types, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package imei_pkg;

    localparam int FRAC_BITS_DEF  = 24;
    localparam int COUNT_BITS_DEF = 16;
    localparam int STEP_FRAC      = 24;
    localparam int PIX_W          = 12;
    localparam int OFF_W          = 13;
    localparam int STEP_W         = 24;
    localparam int ITER_W         = 16;
    localparam int CFG_INDEX_W    = 4;
    localparam int CFG_DATA_W     = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_X       = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET_Y       = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_STEP     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITERATIONS = 4'd3;

    localparam logic [STEP_W-1:0] PIXEL_STEP_RST = 24'd65536;
    localparam logic [ITER_W-1:0] MAX_ITER_RST   = 16'd256;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } req_t;

    typedef struct packed {
        logic [ITER_W-1:0] iteration_count;
        logic              inside_res;
    } res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PMUL,
        ST_PACK,
        ST_DEN,
        ST_DIVR,
        ST_WAITR,
        ST_DIVI,
        ST_WAITI,
        ST_MUL,
        ST_STEP,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/inverted_mandelbrot_escape_top.sv =====
// Set-up is dominated by the bit-serial reciprocal divider, run once for each part
// of c; then each iteration of z*z+c passes through the multiply and step states.
// One pixel is worked on at a time; a finished result waits in the output
// register while the next request is taken. Reset restores the register
// defaults and empties the pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Inverted Mandelbrot escape-time unit
// Maps a pixel to a point, inverts it and counts escape-time iterations.
// ----------------------------------------------------------------------------
`default_nettype none

module inverted_mandelbrot_escape_top #(
    parameter int FRAC_BITS  = imei_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = imei_pkg::COUNT_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire imei_pkg::req_t                      req_data,
    output logic                                     res_valid,
    input  wire logic                                res_stall,
    output imei_pkg::res_t                           res_data,
    input  wire logic                                cfg_we,
    input  wire logic [imei_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [imei_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int VAL_BITS = FRAC_BITS + 8;
    localparam int PW       = 2 * VAL_BITS;
    localparam int SH       = FRAC_BITS - imei_pkg::STEP_FRAC;
    localparam int SHL      = (SH > 0) ? SH : 0;
    localparam int SHR      = (SH < 0) ? -SH : 0;
    localparam int PRW      = imei_pkg::OFF_W + imei_pkg::STEP_W;
    localparam int MW0      = PRW + SHL + 1;
    localparam int MW       = (MW0 > VAL_BITS + 1) ? MW0 : VAL_BITS + 1;
    localparam logic [MW-1:0] RND  = (MW'(1) << SHR) - MW'(1);
    localparam logic [MW-1:0] HALF = MW'(1) << (VAL_BITS - 1);
    localparam logic [PW:0]   FOUR = (PW+1)'(1) << (2 * FRAC_BITS + 2);

    imei_pkg::state_t state_reg;
    imei_pkg::state_t state_next;

    logic signed [imei_pkg::OFF_W-1:0] offx_reg;
    logic signed [imei_pkg::OFF_W-1:0] offy_reg;
    logic [imei_pkg::STEP_W-1:0]       step_reg;
    logic [imei_pkg::ITER_W-1:0]       maxit_reg;

    logic signed [imei_pkg::OFF_W:0]   dx_reg;
    logic signed [imei_pkg::OFF_W:0]   dy_reg;
    logic [PRW-1:0]                    prodx_reg;
    logic [PRW-1:0]                    prody_reg;
    logic                              negx_reg;
    logic                              negy_reg;
    logic signed [VAL_BITS-1:0]        pr_reg;
    logic signed [VAL_BITS-1:0]        pi_reg;
    logic signed [PW-1:0]              sqr_reg;
    logic signed [PW-1:0]              sqi_reg;
    logic signed [VAL_BITS-1:0]        cr_reg;
    logic signed [VAL_BITS-1:0]        ci_reg;
    logic signed [VAL_BITS-1:0]        zr_reg;
    logic signed [VAL_BITS-1:0]        zi_reg;
    logic signed [PW-1:0]              a2_reg;
    logic signed [PW-1:0]              b2_reg;
    logic signed [PW-1:0]              ab_reg;
    logic [COUNT_BITS-1:0]             count_reg;
    logic                              first_reg;
    logic                              res_valid_reg;
    imei_pkg::res_t                    res_reg;

    logic [COUNT_BITS-1:0]   limit;
    logic [COUNT_BITS-1:0]   fault_count;
    logic [imei_pkg::OFF_W-1:0] magx;
    logic [imei_pkg::OFF_W-1:0] magy;
    logic [MW-1:0]           mx;
    logic [MW-1:0]           my;
    logic                    pack_ok;
    logic [VAL_BITS-1:0]     pr_mag;
    logic [VAL_BITS-1:0]     pi_mag;
    logic signed [PW+1:0]    d_w;
    logic signed [PW+1:0]    ab2_w;
    logic signed [PW+1:0]    t_r;
    logic signed [PW+1:0]    t_i;
    logic                    step_ok;
    logic [PW:0]             esc_sum;
    logic                    escaped;
    logic                    at_limit;
    logic                    load_res;

    logic                       div_start;
    logic [VAL_BITS-1:0]        div_num;
    logic [PW-1:0]              div_den;
    logic                       div_neg;
    logic                       div_done;
    logic                       div_ovf;
    logic signed [VAL_BITS-1:0] div_quot;

    imei_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .neg   (div_neg),
        .done  (div_done),
        .ovf   (div_ovf),
        .quot  (div_quot)
    );

    assign limit       = COUNT_BITS'(maxit_reg);
    assign fault_count = (limit != '0) ? COUNT_BITS'(1) : '0;

    always_comb
    begin
        magx = dx_reg[imei_pkg::OFF_W] ? imei_pkg::OFF_W'(-dx_reg)
                                       : imei_pkg::OFF_W'(dx_reg);
        magy = dy_reg[imei_pkg::OFF_W] ? imei_pkg::OFF_W'(-dy_reg)
                                       : imei_pkg::OFF_W'(dy_reg);
        mx = ((MW'(prodx_reg) << SHL) + (negx_reg ? RND : '0)) >> SHR;
        my = ((MW'(prody_reg) << SHL) + (negy_reg ? RND : '0)) >> SHR;
        pack_ok = (negx_reg ? (mx <= HALF) : (mx < HALF)) &&
                  (negy_reg ? (my <= HALF) : (my < HALF)) &&
                  ((mx != '0) || (my != '0));
        pr_mag = pr_reg[VAL_BITS-1] ? VAL_BITS'(-pr_reg) : VAL_BITS'(pr_reg);
        pi_mag = pi_reg[VAL_BITS-1] ? VAL_BITS'(-pi_reg) : VAL_BITS'(pi_reg);

        d_w     = (PW+2)'(a2_reg) - (PW+2)'(b2_reg);
        ab2_w   = (PW+2)'(ab_reg) <<< 1;
        t_r     = (d_w >>> FRAC_BITS) + (PW+2)'(cr_reg);
        t_i     = (ab2_w >>> FRAC_BITS) + (PW+2)'(ci_reg);
        step_ok = ((t_r[PW+1:VAL_BITS-1] == '0) || (t_r[PW+1:VAL_BITS-1] == '1)) &&
                  ((t_i[PW+1:VAL_BITS-1] == '0) || (t_i[PW+1:VAL_BITS-1] == '1));
        esc_sum  = {1'b0, a2_reg} + {1'b0, b2_reg};
        escaped  = !first_reg && (esc_sum >= FOUR);
        at_limit = (count_reg == limit);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            imei_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = imei_pkg::ST_PMUL;
                end
            end
            imei_pkg::ST_PMUL:
            begin
                state_next = imei_pkg::ST_PACK;
            end
            imei_pkg::ST_PACK:
            begin
                state_next = pack_ok ? imei_pkg::ST_DEN : imei_pkg::ST_DONE;
            end
            imei_pkg::ST_DEN:
            begin
                state_next = imei_pkg::ST_DIVR;
            end
            imei_pkg::ST_DIVR:
            begin
                state_next = imei_pkg::ST_WAITR;
            end
            imei_pkg::ST_WAITR:
            begin
                if (div_done)
                begin
                    state_next = div_ovf ? imei_pkg::ST_DONE : imei_pkg::ST_DIVI;
                end
            end
            imei_pkg::ST_DIVI:
            begin
                state_next = imei_pkg::ST_WAITI;
            end
            imei_pkg::ST_WAITI:
            begin
                if (div_done)
                begin
                    state_next = div_ovf ? imei_pkg::ST_DONE : imei_pkg::ST_MUL;
                end
            end
            imei_pkg::ST_MUL:
            begin
                state_next = imei_pkg::ST_STEP;
            end
            imei_pkg::ST_STEP:
            begin
                if (escaped || at_limit || !step_ok)
                begin
                    state_next = imei_pkg::ST_DONE;
                end
                else
                begin
                    state_next = imei_pkg::ST_MUL;
                end
            end
            imei_pkg::ST_DONE:
            begin
                if (!res_valid_reg || !res_stall)
                begin
                    state_next = imei_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = imei_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = (state_reg != imei_pkg::ST_IDLE);
        load_res  = (state_reg == imei_pkg::ST_DONE) && (!res_valid_reg || !res_stall);
        div_start = (state_reg == imei_pkg::ST_DIVR) || (state_reg == imei_pkg::ST_DIVI);
        div_den   = PW'($unsigned(sqr_reg)) + PW'($unsigned(sqi_reg));
        if (state_reg == imei_pkg::ST_DIVI)
        begin
            div_num = pi_mag;
            div_neg = !pi_reg[VAL_BITS-1] && (pi_reg != '0);
        end
        else
        begin
            div_num = pr_mag;
            div_neg = pr_reg[VAL_BITS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imei_pkg::ST_IDLE;
            res_valid_reg <= 1'b0;
            offx_reg      <= '0;
            offy_reg      <= '0;
            step_reg      <= imei_pkg::PIXEL_STEP_RST;
            maxit_reg     <= imei_pkg::MAX_ITER_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    imei_pkg::CFG_OFFSET_X:
                    begin
                        offx_reg <= $signed(cfg_data[imei_pkg::OFF_W-1:0]);
                    end
                    imei_pkg::CFG_OFFSET_Y:
                    begin
                        offy_reg <= $signed(cfg_data[imei_pkg::OFF_W-1:0]);
                    end
                    imei_pkg::CFG_PIXEL_STEP:
                    begin
                        step_reg <= cfg_data[imei_pkg::STEP_W-1:0];
                    end
                    imei_pkg::CFG_MAX_ITERATIONS:
                    begin
                        maxit_reg <= cfg_data[imei_pkg::ITER_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            imei_pkg::ST_IDLE:
            begin
                dx_reg <= $signed({2'b00, req_data.pixel_x}) - $signed({offx_reg[12], offx_reg});
                dy_reg <= $signed({2'b00, req_data.pixel_y}) - $signed({offy_reg[12], offy_reg});
            end
            imei_pkg::ST_PMUL:
            begin
                prodx_reg <= PRW'(magx) * PRW'(step_reg);
                prody_reg <= PRW'(magy) * PRW'(step_reg);
                negx_reg  <= dx_reg[imei_pkg::OFF_W];
                negy_reg  <= !dy_reg[imei_pkg::OFF_W] && (dy_reg != '0);
            end
            imei_pkg::ST_PACK:
            begin
                pr_reg    <= negy_reg ? -$signed(my[VAL_BITS-1:0]) : $signed(my[VAL_BITS-1:0]);
                pi_reg    <= negx_reg ? -$signed(mx[VAL_BITS-1:0]) : $signed(mx[VAL_BITS-1:0]);
                count_reg <= fault_count;
            end
            imei_pkg::ST_DEN:
            begin
                sqr_reg <= pr_reg * pr_reg;
                sqi_reg <= pi_reg * pi_reg;
            end
            imei_pkg::ST_WAITR:
            begin
                cr_reg    <= div_quot;
                count_reg <= fault_count;
            end
            imei_pkg::ST_WAITI:
            begin
                ci_reg    <= div_quot;
                zr_reg    <= cr_reg;
                zi_reg    <= div_quot;
                first_reg <= 1'b1;
                count_reg <= div_ovf ? fault_count : '0;
            end
            imei_pkg::ST_MUL:
            begin
                a2_reg <= zr_reg * zr_reg;
                b2_reg <= zi_reg * zi_reg;
                ab_reg <= zr_reg * zi_reg;
            end
            imei_pkg::ST_STEP:
            begin
                if (!escaped && !at_limit)
                begin
                    count_reg <= count_reg + COUNT_BITS'(1);
                    zr_reg    <= t_r[VAL_BITS-1:0];
                    zi_reg    <= t_i[VAL_BITS-1:0];
                    first_reg <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        if (load_res)
        begin
            res_reg.iteration_count <= imei_pkg::ITER_W'(count_reg);
            res_reg.inside_res      <= at_limit;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/imei_cell.sv =====
// ----------------------------------------------------------------------------
// Divider chain cell
// One bit of the dividend and quotient line: loads a dividend bit, then takes
// its lower neighbour's bit on every shift.
// ----------------------------------------------------------------------------
`default_nettype none

module imei_cell (
    input  wire logic clk,
    input  wire logic load,
    input  wire logic shift,
    input  wire logic load_bit,
    input  wire logic shift_in,
    output logic      bit_q
);

    logic bit_reg;
    logic bit_next;

    always_comb
    begin
        bit_next = bit_reg;
        if (load)
        begin
            bit_next = load_bit;
        end
        else if (shift)
        begin
            bit_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg <= bit_next;
    end

    assign bit_q = bit_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/imei_div.sv =====
// ----------------------------------------------------------------------------
// Reciprocal divider
// Restoring division of a magnitude scaled by two to the power of twice the
// fraction width, one quotient bit per cycle through a chain of cells.
// ----------------------------------------------------------------------------
`default_nettype none

module imei_div #(
    parameter int FRAC_BITS = imei_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [FRAC_BITS+7:0]        num,
    input  wire logic [2*FRAC_BITS+15:0]     den,
    input  wire logic                        neg,
    output logic                             done,
    output logic                             ovf,
    output logic signed [FRAC_BITS+7:0]      quot
);

    localparam int VAL_BITS = FRAC_BITS + 8;
    localparam int PW       = 2 * VAL_BITS;
    localparam int LEN      = VAL_BITS + 2 * FRAC_BITS;
    localparam int CNTW     = $clog2(LEN + 1);
    localparam int UPW      = LEN - VAL_BITS + 1;

    logic [LEN-1:0]  chain;
    logic [PW-1:0]   rem_reg;
    logic [PW-1:0]   rem_next;
    logic [PW-1:0]   den_reg;
    logic            neg_reg;
    logic            run_reg;
    logic            run_next;
    logic            done_reg;
    logic            done_next;
    logic [CNTW-1:0] cnt_reg;
    logic [CNTW-1:0] cnt_next;
    logic [PW:0]     trial;
    logic            qbit;
    logic [UPW-1:0]  upper;

    genvar gi;
    generate
        for (gi = 0; gi < LEN; gi++)
        begin : g_cell
            logic lb;
            logic si;
            if (gi >= 2 * FRAC_BITS)
            begin : g_num
                assign lb = num[gi-2*FRAC_BITS];
            end
            else
            begin : g_zero
                assign lb = 1'b0;
            end
            if (gi == 0)
            begin : g_first
                assign si = qbit;
            end
            else
            begin : g_next
                assign si = chain[gi-1];
            end
            imei_cell u_cell (
                .clk      (clk),
                .load     (start),
                .shift    (run_reg),
                .load_bit (lb),
                .shift_in (si),
                .bit_q    (chain[gi])
            );
        end
    endgenerate

    always_comb
    begin
        trial     = {rem_reg, chain[LEN-1]};
        qbit      = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            run_next = 1'b1;
            cnt_next = CNTW'(LEN);
        end
        else if (run_reg)
        begin
            rem_next = qbit ? PW'(trial - {1'b0, den_reg}) : trial[PW-1:0];
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= den;
            neg_reg <= neg;
        end
    end

    assign upper = chain[LEN-1:VAL_BITS-1];
    assign ovf   = !((upper == '0) ||
                     (neg_reg && (upper == UPW'(1)) && (chain[VAL_BITS-2:0] == '0)));
    assign quot  = neg_reg ? -$signed(chain[VAL_BITS-1:0]) : $signed(chain[VAL_BITS-1:0]);
    assign done  = done_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/imei_chk.sv =====
// ----------------------------------------------------------------------------
// Escape-time unit port checker
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module imei_chk (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           req_valid,
    input wire logic           req_stall,
    input wire logic           res_valid,
    input wire logic           res_stall,
    input wire imei_pkg::res_t res_data
);

    // A held result keeps its value until it is taken.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // Only a zero limit gives a zero count, and that is always inside.
    a_zero_inside: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_data.iteration_count == '0) |-> res_data.inside_res)
        else $error("zero count without inside flag");

    // The unit works on one pixel at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("second request taken while busy");

endmodule

bind inverted_mandelbrot_escape_top imei_chk u_imei_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);

`default_nettype wire

// ===== tb/sv/inverted_mandelbrot_escape_top_tb.sv =====
// ----------------------------------------------------------------------------
// Inverted Mandelbrot escape-time unit testbench
// Sends pixel requests under random handshake gaps and stalls and checks each
// iteration count and inside flag against a fixed-point model of the unit.
// ----------------------------------------------------------------------------
`default_nettype none

module inverted_mandelbrot_escape_top_tb;

    import imei_pkg::*;

    typedef logic signed [127:0] wide_t;

    localparam int WATCHDOG_LIMIT = 400000;

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_stall;
    req_t                   req_data;
    logic                   res_valid;
    logic                   res_stall;
    res_t                   res_data;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    longint origin_col;
    longint origin_row;
    longint step_size;
    longint iter_limit;

    res_t   pending_counts[$];
    int     mismatches;
    int     failures;
    int     idle_cycles;
    bit     timed_out;
    bit     no_gaps;
    int     pixels_sent;

    inverted_mandelbrot_escape_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic bit fits_value(input wide_t t, output longint v);
        if (t < -(wide_t'(1) <<< 31) || t > ((wide_t'(1) <<< 31) - 1))
        begin
            v = 0;
            return 1'b0;
        end
        v = longint'(t);
        return 1'b1;
    endfunction

    function automatic wide_t magnitude(input wide_t t);
        return (t < 0) ? -t : t;
    endfunction

    function automatic res_t escape_count(input logic [PIX_W-1:0] px,
                                          input logic [PIX_W-1:0] py);
        longint dx, dy, pr, pim, cr, ci, zr, zi, nr, ni;
        wide_t  den, q, d, ab;
        longint cnt;
        bit     fault, ok;
        res_t   r;
        cnt   = 0;
        dx    = longint'(px) - origin_col;
        dy    = longint'(py) - origin_row;
        fault = !fits_value(-(wide_t'(dy) * wide_t'(step_size)), pr)
             || !fits_value(wide_t'(dx) * wide_t'(step_size), pim);
        if (!fault && pr == 0 && pim == 0)
            fault = 1'b1;
        if (!fault)
        begin
            den = wide_t'(pr) * wide_t'(pr) + wide_t'(pim) * wide_t'(pim);
            q = (magnitude(wide_t'(pr)) <<< 48) / den;
            fault = !fits_value((pr < 0) ? -q : q, cr);
            q = (magnitude(wide_t'(pim)) <<< 48) / den;
            fault = fault || !fits_value((pim > 0) ? -q : q, ci);
        end
        if (fault)
        begin
            if (iter_limit > 0)
                cnt = 1;
        end
        else
        begin
            zr = cr;
            zi = ci;
            while (cnt < iter_limit)
            begin
                d  = wide_t'(zr) * wide_t'(zr) - wide_t'(zi) * wide_t'(zi);
                ab = (wide_t'(zr) * wide_t'(zi)) <<< 1;
                ok = fits_value((d >>> 24) + wide_t'(cr), nr)
                  && fits_value((ab >>> 24) + wide_t'(ci), ni);
                cnt++;
                if (!ok)
                    break;
                zr = nr;
                zi = ni;
                if (wide_t'(zr) * wide_t'(zr) + wide_t'(zi) * wide_t'(zi)
                    >= (wide_t'(4) <<< 48))
                    break;
            end
        end
        r.iteration_count = cnt[ITER_W-1:0];
        r.inside_res      = (cnt == iter_limit);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_counts.size() == 0)
            begin
                failures++;
                if (mismatches < 10)
                    $display("unexpected result: count %0d inside %0d",
                             res_data.iteration_count, res_data.inside_res);
                mismatches++;
            end
            else
            begin
                res_t exp_r;
                exp_r = pending_counts.pop_front();
                if (exp_r.iteration_count !== res_data.iteration_count
                    || exp_r.inside_res !== res_data.inside_res)
                begin
                    failures++;
                    if (mismatches < 10)
                        $display("mismatch: expected count %0d inside %0d, got count %0d inside %0d",
                                 exp_r.iteration_count, exp_r.inside_res,
                                 res_data.iteration_count, res_data.inside_res);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("[inverted_mandelbrot_escape_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        int n;
        res_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = no_gaps ? 0 : $urandom_range(0, 17);
            if (n > 0)
            begin
                res_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            res_stall <= 1'b0;
            do
                @(posedge clk);
            while (!res_valid);
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid        <= 1'b1;
        req_data.pixel_x <= px;
        req_data.pixel_y <= py;
        do
            @(posedge clk);
        while (req_stall);
        pending_counts.push_back(escape_count(px, py));
        pixels_sent++;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        req_valid <= 1'b0;
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_OFFSET_X:       origin_col = longint'(signed'(val[OFF_W-1:0]));
            CFG_OFFSET_Y:       origin_row = longint'(signed'(val[OFF_W-1:0]));
            CFG_PIXEL_STEP:     step_size  = longint'(val);
            CFG_MAX_ITERATIONS: iter_limit = longint'(val[ITER_W-1:0]);
            default:            ;
        endcase
    endtask

    task automatic set_view(input int col, input int row, input int stp, input int lim);
        write_reg(CFG_OFFSET_X, CFG_DATA_W'(col));
        write_reg(CFG_OFFSET_Y, CFG_DATA_W'(row));
        write_reg(CFG_PIXEL_STEP, CFG_DATA_W'(stp));
        write_reg(CFG_MAX_ITERATIONS, CFG_DATA_W'(lim));
    endtask

    task automatic test_reset_defaults();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd200, 12'd100);
        send_pixel(12'd0, 12'd300);
        send_pixel(12'd4095, 12'd4095);
    endtask

    task automatic test_field_extremes();
        set_view(-4096, 4095, 1, 1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        set_view(4095, -4096, 16777215, 65535);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        set_view(2048, 2048, 16777215, 40);
        send_pixel(12'd2049, 12'd2048);
        send_pixel(12'd2048, 12'd2047);
        send_pixel(12'd2048, 12'd2048);
    endtask

    task automatic test_zero_limit_and_step();
        set_view(100, 100, 1 << 22, 0);
        send_pixel(12'd103, 12'd99);
        send_pixel(12'd100, 12'd100);
        write_reg(CFG_MAX_ITERATIONS, 24'd50);
        write_reg(CFG_PIXEL_STEP, 24'd0);
        send_pixel(12'd5, 12'd3000);
        send_pixel(12'd4000, 12'd17);
    endtask

    task automatic test_ignored_index();
        write_reg(CFG_PIXEL_STEP, 24'd1 << 22);
        for (int k = 4; k < 16; k++)
            write_reg(CFG_INDEX_W'(k), CFG_DATA_W'($urandom));
        send_pixel(12'd103, 12'd101);
        send_pixel(12'd98, 12'd100);
    endtask

    task automatic test_full_limit();
        set_view(500, 498, 1 << 23, 65535);
        send_pixel(12'd500, 12'd500);
        send_pixel(12'd500, 12'd498);
        send_pixel(12'd502, 12'd500);
    endtask

    task automatic test_random_views();
        int col, row, stp, lim, n, dxr, pick;
        while (pixels_sent < 1380)
        begin
            no_gaps = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 9);
            col  = $urandom_range(0, 8191) - 4096;
            row  = $urandom_range(0, 8191) - 4096;
            if (pick < 7)
            begin
                col = $urandom_range(0, 4095);
                row = $urandom_range(0, 4095);
            end
            stp = (pick == 9) ? $urandom_range(1, 16777215)
                              : (1 << 24) / $urandom_range(1, 96);
            case ($urandom_range(0, 5))
                0: lim = $urandom_range(1, 4);
                1: lim = 256;
                2: lim = $urandom_range(0, 300);
                default: lim = $urandom_range(1, 64);
            endcase
            set_view(col, row, stp, lim);
            n = $urandom_range(10, 40);
            dxr = $urandom_range(4, 120);
            repeat (n)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_pixel(PIX_W'($urandom), PIX_W'($urandom));
                else
                    send_pixel(PIX_W'(col + $urandom_range(0, 2 * dxr) - dxr),
                               PIX_W'(row + $urandom_range(0, 2 * dxr) - dxr));
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        int guard;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_data   = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        origin_col = 0;
        origin_row = 0;
        step_size  = longint'(PIXEL_STEP_RST);
        iter_limit = longint'(MAX_ITER_RST);
        mismatches = 0;
        failures   = 0;
        timed_out  = 1'b0;
        no_gaps    = 1'b0;
        pixels_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_zero_limit_and_step();
        test_ignored_index();
        test_full_limit();
        test_random_views();

        @(posedge clk);
        req_valid <= 1'b0;
        guard = 0;
        while (pending_counts.size() != 0 && guard < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
        if (failures == 0 && pending_counts.size() == 0)
            $display("[inverted_mandelbrot_escape_top] OK");
        else
            $display("[inverted_mandelbrot_escape_top] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
